@@ sv/qsilu_pkg.sv @@
// Shared types, constants and helper functions for the quantized SiLU pipeline.
// No dependencies; every other file imports this package.
package qsilu_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_IN_SCALE      = 2'd0,
      CSR_INV_SCALE_OUT = 2'd1,
      CSR_ACT_MIN       = 2'd2,
      CSR_ACT_MAX       = 2'd3
   } csr_index_type;

   localparam logic [16:0] Log2eQ16   = 17'd94548;
   localparam logic [29:0] Ln2Q30     = 30'd744261118;
   localparam logic [30:0] OneQ30     = 31'h4000_0000;
   localparam int unsigned TaylorTerms = 6;
   localparam int unsigned QuotBits   = 17;

   // reciprocals ceil(2^33 / j) for exact floor division of values below 2^30
   localparam logic [31:0] Recip3 = 32'd2863311531;
   localparam logic [31:0] Recip5 = 32'd1717986919;
   localparam logic [31:0] Recip6 = 32'd1431655766;

   // front end -> exp unit
   typedef struct packed {
      logic [29:0]        u;
      logic [8:0]         k;
      logic signed [23:0] f;
   } exp_arg_type;

   // exp unit -> divider
   typedef struct packed {
      logic [30:0]        e;
      logic signed [23:0] f;
   } exp_res_type;

   // divider -> back end
   typedef struct packed {
      logic [16:0]        s;
      logic signed [23:0] f;
   } sig_res_type;

   // floor(p / j) for j in 1..6, p below 2^30
   function automatic logic [29:0] div_small(input logic [29:0] p, input int unsigned j);
      logic [61:0] prod;
      prod = '0;
      unique case (j)
         3: prod = {32'd0, p} * {30'd0, Recip3};
         5: prod = {32'd0, p} * {30'd0, Recip5};
         6: prod = {32'd0, p} * {30'd0, Recip6};
         default: prod = '0;
      endcase
      unique case (j)
         2: return p >> 1;
         4: return p >> 2;
         3, 5, 6: return {1'b0, prod[61:33]};
         default: return p;
      endcase
   endfunction

endpackage

@@ sv/quantized_silu_s8.sv @@
// Top level of the int8 SiLU activation pipeline: CSRs, flow control, stage modules.
// Depends on qsilu_pkg, qsilu_front, qsilu_exp, qsilu_div, qsilu_back.
//
// Usage:
//   req_* carries one signed 8-bit quantized sample per item; rsp_* returns one
//   signed 8-bit SiLU result per item, in order. csr_* writes the four settings
//   (0 in_scale Q4.20, 1 inv_scale_out Q8.16, 2 act_min, 3 act_max); write them
//   only while the pipeline is empty.
//   Throughput: one item per cycle while the output is not stalled. The stages
//   include the 17 one-bit divider stages for the sigmoid and the two stages per
//   term of the six-term exp evaluation.
//   Reset (synchronous, active high) drops every item in flight and restores
//   in_scale = 1.0, inv_scale_out = 1.0, act_min = -128, act_max = 127.
//   Stall: while a result waits in the output register and rsp_tready is low,
//   the whole pipeline holds and req_tready drops; nothing is lost or repeated.
//   Bubbles in the pipeline still fill while the output is free.
module quantized_silu_s8 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [7:0] activation
   input  logic                                 csr_we,
   input  logic [qsilu_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [qsilu_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import qsilu_pkg::*;

   logic [23:0]        in_scale_ff;
   logic [23:0]        inv_scale_out_ff;
   logic signed [7:0]  act_min_ff;
   logic signed [7:0]  act_max_ff;
   logic               en;
   logic               front_valid, exp_valid, div_valid;
   exp_arg_type        front_arg;
   exp_res_type        exp_res;
   sig_res_type        div_res;
   logic signed [7:0]  activation;

   // advance every stage unless a finished item is stuck at the output
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // hold configuration; writes are to land only while idle (user's duty, not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         in_scale_ff      <= 24'd1048576;
         inv_scale_out_ff <= 24'd65536;
         act_min_ff       <= -8'sd128;
         act_max_ff       <= 8'sd127;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_SCALE:      in_scale_ff      <= csr_wdata;
            CSR_INV_SCALE_OUT: inv_scale_out_ff <= csr_wdata;
            CSR_ACT_MIN:       act_min_ff       <= csr_wdata[7:0];
            CSR_ACT_MAX:       act_max_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   qsilu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_tvalid),
      .sample    (req_tdata),
      .in_scale  (in_scale_ff),
      .valid_out (front_valid),
      .arg_out   (front_arg)
   );

   qsilu_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (front_valid),
      .arg_in    (front_arg),
      .valid_out (exp_valid),
      .res_out   (exp_res)
   );

   qsilu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (exp_valid),
      .res_in    (exp_res),
      .valid_out (div_valid),
      .res_out   (div_res)
   );

   qsilu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .valid_in      (div_valid),
      .res_in        (div_res),
      .inv_scale_out (inv_scale_out_ff),
      .act_min       (act_min_ff),
      .act_max       (act_max_ff),
      .valid_out     (rsp_tvalid),
      .activation    (activation)
   );

   assign rsp_tdata = activation;

endmodule

@@ sv/qsilu_front.sv @@
// Front end: dequantize, saturate to Q8.16, scale |f| by log2(e), split k/r, form u.
// Depends on qsilu_pkg.
module qsilu_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       valid_in,
   input  logic signed [7:0]          sample,
   input  logic [23:0]                in_scale,
   output logic                       valid_out,
   output qsilu_pkg::exp_arg_type     arg_out
);
   import qsilu_pkg::*;

   logic [3:0]         valid_ff;
   logic signed [32:0] prod_ff, prod_in;
   logic signed [23:0] f2_ff, f2_in, f3_ff, f4_ff;
   logic [23:0]        a2_ff, a2_in;
   logic [24:0]        t_ff, t_in;
   logic [29:0]        u_ff, u_in;
   logic [8:0]         k_ff;
   logic [32:0]        mag;
   logic [28:0]        rnd;
   logic [40:0]        tprod;
   logic [45:0]        uprod;

   always_comb begin
      prod_in = $signed({{25{sample[7]}}, sample}) * $signed({9'd0, in_scale});
      mag     = prod_ff[32] ? 33'(-prod_ff) : 33'(prod_ff);
      rnd     = 29'((mag + 33'd8) >> 4);
      if (prod_ff[32]) begin
         a2_in = (rnd > 29'h80_0000) ? 24'h80_0000 : rnd[23:0];
         f2_in = $signed(24'(-a2_in));
      end else begin
         a2_in = (rnd > 29'h7F_FFFF) ? 24'h7F_FFFF : rnd[23:0];
         f2_in = $signed(a2_in);
      end
      tprod = {17'd0, a2_ff} * {24'd0, Log2eQ16};
      t_in  = tprod[40:16];
      uprod = {30'd0, t_ff[15:0]} * {16'd0, Ln2Q30};
      u_in  = uprod[45:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         f2_ff   <= f2_in;
         a2_ff   <= a2_in;
         t_ff    <= t_in;
         f3_ff   <= f2_ff;
         u_ff    <= u_in;
         k_ff    <= t_ff[24:16];
         f4_ff   <= f3_ff;
      end
   end

   assign valid_out = valid_ff[3];
   assign arg_out   = '{u: u_ff, k: k_ff, f: f4_ff};

endmodule

@@ sv/qsilu_exp.sv @@
// Exp unit: six-term Horner evaluation of exp(-u), two stages per term, then the 2^-k shift.
// Depends on qsilu_pkg.
module qsilu_exp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  qsilu_pkg::exp_arg_type arg_in,
   output logic                   valid_out,
   output qsilu_pkg::exp_res_type res_out
);
   import qsilu_pkg::*;

   localparam int unsigned Stages = 2 * TaylorTerms;

   logic               valid_ff [Stages+1];
   exp_arg_type        arg_ff   [Stages+1];
   logic [30:0]        q_ff     [Stages+1];
   logic [29:0]        p_ff     [Stages+1];
   logic               e_valid_ff;
   exp_res_type        res_ff, res_in;

   assign valid_ff[0] = valid_in;
   assign arg_ff[0]   = arg_in;
   assign q_ff[0]     = OneQ30;
   assign p_ff[0]     = '0;

   for (genvar g = 0; g < TaylorTerms; g++) begin : g_term
      localparam int unsigned J = TaylorTerms - g;
      logic [60:0] pq;
      logic [29:0] p_in;
      logic [30:0] q_in;

      always_comb begin
         pq   = {31'd0, arg_ff[2*g].u} * {30'd0, q_ff[2*g]};
         p_in = pq[59:30];
         q_in = OneQ30 - {1'b0, div_small(p_ff[2*g+1], J)};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[2*g+1] <= 1'b0;
            valid_ff[2*g+2] <= 1'b0;
         end else if (en) begin
            valid_ff[2*g+1] <= valid_ff[2*g];
            valid_ff[2*g+2] <= valid_ff[2*g+1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            arg_ff[2*g+1] <= arg_ff[2*g];
            p_ff[2*g+1]   <= p_in;
            q_ff[2*g+1]   <= q_ff[2*g];
            arg_ff[2*g+2] <= arg_ff[2*g+1];
            p_ff[2*g+2]   <= p_ff[2*g+1];
            q_ff[2*g+2]   <= q_in;
         end
      end
   end

   always_comb begin
      res_in.f = arg_ff[Stages].f;
      if (arg_ff[Stages].k >= 9'd31) begin
         res_in.e = '0;
      end else begin
         res_in.e = q_ff[Stages] >> arg_ff[Stages].k[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= valid_ff[Stages];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign valid_out = e_valid_ff;
   assign res_out   = res_ff;

endmodule

@@ sv/qsilu_div.sv @@
// Sigmoid divider: rounded quotient over 2^30 + E, restoring, one quotient bit per stage.
// Depends on qsilu_pkg.
module qsilu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  qsilu_pkg::exp_res_type res_in,
   output logic                   valid_out,
   output qsilu_pkg::sig_res_type res_out
);
   import qsilu_pkg::*;

   logic                 valid_ff [QuotBits+1];
   logic [31:0]          rem_ff   [QuotBits+1];
   logic [QuotBits-1:0]  nq_ff    [QuotBits+1];
   logic [31:0]          den_ff   [QuotBits+1];
   logic signed [23:0]   f_ff     [QuotBits+1];
   logic [31:0]          den_in;
   logic [46:0]          num_in;

   always_comb begin
      den_in = 32'h4000_0000 + {1'b0, res_in.e};
      if (!res_in.f[23]) begin
         num_in = (47'd1 << 46) + {16'd0, den_in[31:1]};
      end else begin
         num_in = {res_in.e, 16'd0} + {16'd0, den_in[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {2'd0, num_in[46:17]};
         nq_ff[0]  <= num_in[16:0];
         den_ff[0] <= den_in;
         f_ff[0]   <= res_in.f;
      end
   end

   for (genvar g = 0; g < QuotBits; g++) begin : g_bit
      logic [31:0] sh;
      logic        ge;

      always_comb begin
         sh = {rem_ff[g][30:0], nq_ff[g][QuotBits-1]};
         ge = (sh >= den_ff[g]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            valid_ff[g+1] <= valid_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1] <= ge ? (sh - den_ff[g]) : sh;
            nq_ff[g+1]  <= {nq_ff[g][QuotBits-2:0], ge};
            den_ff[g+1] <= den_ff[g];
            f_ff[g+1]   <= f_ff[g];
         end
      end
   end

   assign valid_out = valid_ff[QuotBits];
   assign res_out   = '{s: nq_ff[QuotBits], f: f_ff[QuotBits]};

endmodule

@@ sv/qsilu_back.sv @@
// Back end: f * sigmoid, requantize by inv_scale_out, round, clamp; last stage is the output register.
// Depends on qsilu_pkg.
module qsilu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  qsilu_pkg::sig_res_type res_in,
   input  logic [23:0]            inv_scale_out,
   input  logic signed [7:0]      act_min,
   input  logic signed [7:0]      act_max,
   output logic                   valid_out,
   output logic signed [7:0]      activation
);
   import qsilu_pkg::*;

   logic [3:0]         valid_ff;
   logic signed [41:0] fs_ff, fs_in;
   logic signed [24:0] y_ff, y_in;
   logic signed [49:0] yv_ff, yv_in;
   logic signed [7:0]  act_ff, act_in;
   logic [41:0]        fs_mag;
   logic [25:0]        y_rnd;
   logic [49:0]        yv_mag;
   logic [17:0]        v_rnd;
   logic signed [17:0] v;
   logic signed [17:0] lo, hi;

   always_comb begin
      fs_in  = $signed({{18{res_in.f[23]}}, res_in.f}) * $signed({25'd0, res_in.s});
      fs_mag = fs_ff[41] ? 42'(-fs_ff) : 42'(fs_ff);
      y_rnd  = 26'((fs_mag + 42'h8000) >> 16);
      y_in   = fs_ff[41] ? 25'(-y_rnd) : 25'(y_rnd);
      yv_in  = $signed({{25{y_ff[24]}}, y_ff}) * $signed({26'd0, inv_scale_out});
      yv_mag = yv_ff[49] ? 50'(-yv_ff) : 50'(yv_ff);
      v_rnd  = 18'((yv_mag + 50'h8000_0000) >> 32);
      v      = yv_ff[49] ? $signed(18'(-v_rnd)) : $signed(v_rnd);
      lo     = 18'(act_min);
      hi     = 18'(act_max);
      // upper bound checked first, upper bound wins when the bounds cross
      if (v > hi) begin
         act_in = act_max;
      end else if (v < lo) begin
         act_in = (lo > hi) ? act_max : act_min;
      end else begin
         act_in = v[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fs_ff  <= fs_in;
         y_ff   <= y_in;
         yv_ff  <= yv_in;
         act_ff <= act_in;
      end
   end

   assign valid_out  = valid_ff[3];
   assign activation = act_ff;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for quantized_silu_s8: drives signed 8-bit samples, predicts each
// SiLU activation in fixed point and compares it with the result stream, in order.
// Depends on qsilu_pkg (register indexes, widths) and the quantized_silu_s8 RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qsilu_pkg::*;

   localparam int unsigned PipeLatency = 39;
   localparam longint unsigned CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] sample
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [7:0] activation
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_IN_SCALE;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // shadow copy of the block's settings
   logic [23:0] cfg_in_scale;
   logic [23:0] cfg_inv_scale_out;
   logic signed [7:0] cfg_act_min;
   logic signed [7:0] cfg_act_max;

   logic [7:0] expected_activations[$];
   int unsigned error_count = 0;
   int unsigned sample_count = 0;
   int unsigned activation_count = 0;
   longint unsigned cycle_count = 0;
   bit stall_enable = 1'b1;

   quantized_silu_s8 DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the pipeline hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("quantized_silu_s8: mismatch");
         $finish;
      end
   end

   // Round half away from zero while shifting right by n.
   function automatic longint round_shift(longint value, int n);
      longint magnitude;
      magnitude = (value < 0) ? -value : value;
      magnitude = (magnitude + (64'sd1 <<< (n - 1))) >>> n;
      return (value < 0) ? -magnitude : magnitude;
   endfunction

   // exp(-a) in Q.30, a in Q.16; six-term Horner series on the fractional part of a*log2(e).
   function automatic longint unsigned exp_neg(longint unsigned a);
      longint unsigned t, k, r, u, q;
      t = (a * 94548) >> 16;
      k = t >> 16;
      r = t & 64'hFFFF;
      u = (r * 744261118) >> 16;
      q = 64'd1 << 30;
      for (int j = 6; j >= 1; j--) q = (64'd1 << 30) - ((u * q) >> 30) / j;
      return (k >= 31) ? 64'd0 : (q >> k);
   endfunction

   // Predict the activation for one sample under the current settings.
   function automatic logic [7:0] silu_activation(logic signed [7:0] sample);
      longint f, y, v;
      longint unsigned a, e, den, s;
      f = round_shift(longint'(sample) * longint'(cfg_in_scale), 4);
      if (f > 8388607) f = 8388607;
      if (f < -8388608) f = -8388608;
      a = (f < 0) ? -f : f;
      e = exp_neg(a);
      den = (64'd1 << 30) + e;
      if (f >= 0) s = ((64'd1 << 46) + den / 2) / den;
      else s = ((e << 16) + den / 2) / den;
      y = round_shift(f * longint'(s), 16);
      v = round_shift(y * longint'(cfg_inv_scale_out), 32);
      // lower bound first, then upper: crossed bounds give act_max
      if (v < cfg_act_min) v = cfg_act_min;
      if (v > cfg_act_max) v = cfg_act_max;
      return v[7:0];
   endfunction

   // Short gaps mostly, a long one now and then.
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Result checker: accept on tvalid & tready and compare with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         activation_count <= activation_count + 1;
         if (expected_activations.size() == 0) begin
            $error("activation %0d arrived with nothing expected", $signed(rsp_tdata));
            error_count <= error_count + 1;
         end else begin
            logic [7:0] want;
            want = expected_activations.pop_front();
            if (want !== rsp_tdata) begin
               $error("activation: expected %0d, actual %0d", $signed(want),
                      $signed(rsp_tdata));
               error_count <= error_count + 1;
            end
         end
      end
   end

   // Receiver backpressure: hold rsp_tready low for random stretches.
   initial begin
      int unsigned hold;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1'b1;
         hold = $urandom_range(12, 1);
         repeat (hold) @(posedge clock);
         hold = stall_enable ? gap_length() : 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Send one item and queue its predicted activation once accepted.
   task automatic send_sample(logic signed [7:0] sample, bit allow_gap = 1'b1);
      int unsigned gap;
      gap = (allow_gap && stall_enable) ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_activations.push_back(silu_activation(sample));
      sample_count++;
   endtask

   // Drop valid and wait until every expected activation has arrived.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_activations.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register while the pipeline is empty; update the shadow copy.
   task automatic write_setting(csr_index_type index, logic [23:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_IN_SCALE: cfg_in_scale = value;
         CSR_INV_SCALE_OUT: cfg_inv_scale_out = value;
         CSR_ACT_MIN: cfg_act_min = value[7:0];
         CSR_ACT_MAX: cfg_act_max = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [23:0] sin, logic [23:0] sout,
                                 logic signed [7:0] lo, logic signed [7:0] hi);
      write_setting(CSR_IN_SCALE, sin);
      write_setting(CSR_INV_SCALE_OUT, sout);
      write_setting(CSR_ACT_MIN, {16'd0, lo});
      write_setting(CSR_ACT_MAX, {16'd0, hi});
   endtask

   // Extremes and zero under reset settings, then under saturating and zero scales.
   task automatic test_directed_extremes();
      int edges[8] = '{-128, -127, -1, 0, 1, 2, 126, 127};
      foreach (edges[i]) send_sample(8'(edges[i]));
      drain_pipeline();
      // large in_scale saturates f; large inv_scale_out drives the clamp
      apply_settings(24'hFFFFFF, 24'hFFFFFF, 8'(-128), 8'(127));
      foreach (edges[i]) send_sample(8'(edges[i]), 1'b0);
      drain_pipeline();
      // zero scales give zero before clamping
      apply_settings(24'd0, 24'd0, 8'(-128), 8'(127));
      send_sample(8'(-128)); send_sample(8'(5)); send_sample(8'(127));
      drain_pipeline();
   endtask

   // Narrow, crossed and single-point clamp windows.
   task automatic test_clamp_bounds();
      apply_settings(24'h200000, 24'h080000, 8'(-3), 8'(9));
      for (int s = -128; s < 128; s += 37) send_sample(s[7:0]);
      drain_pipeline();
      // crossed bounds: every result should come out as act_max
      apply_settings(24'h100000, 24'h010000, 8'(20), 8'(-20));
      send_sample(8'(-100)); send_sample(8'(0)); send_sample(8'(100));
      drain_pipeline();
      apply_settings(24'h100000, 24'h010000, 8'(127), 8'(127));
      send_sample(8'(-128)); send_sample(8'(127));
      drain_pipeline();
   endtask

   // Random samples under a run of random settings, with idling on both sides.
   task automatic test_random_stream(int unsigned phases, int unsigned per_phase);
      logic signed [7:0] lo, hi;
      for (int p = 0; p < phases; p++) begin
         lo = 8'(int'($urandom_range(60)) - 128);
         hi = 8'(int'($urandom_range(127, 0)) - int'($urandom_range(20)));
         if ($urandom_range(7) == 0) lo = 8'(hi + 5);
         apply_settings(24'((p % 3 == 0) ? $urandom_range(24'hFFFFFF) :
                               $urandom_range(24'h400000, 24'h8000)),
                        24'((p % 4 == 1) ? $urandom_range(24'hFFFFFF) :
                               $urandom_range(24'h100000, 24'h1000)),
                        lo, hi);
         stall_enable = (p % 5 != 2);
         for (int i = 0; i < per_phase; i++) send_sample(8'($urandom()));
         drain_pipeline();
         stall_enable = 1'b1;
      end
   endtask

   initial begin
      ref_reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_clamp_bounds();
      test_random_stream(10, 40);
      // restore reset values: nominal scales, full clamp range
      apply_settings(24'h100000, 24'h010000, 8'(-128), 8'(127));
      for (int i = 0; i < 20; i++) send_sample(8'($urandom()));
      drain_pipeline();
      repeat (PipeLatency) @(posedge clock);
      $display("covered %0d samples, %0d activations checked, across extreme, zero,",
               sample_count, activation_count);
      $display("crossed-bound and random scale and clamp settings with two-sided idling");
      if (error_count == 0 && expected_activations.size() == 0) begin
         $display("quantized_silu_s8: match");
      end else begin
         $display("quantized_silu_s8: mismatch");
      end
      $finish;
   end

   task automatic ref_reset_shadow();
      cfg_in_scale = 24'h100000;
      cfg_inv_scale_out = 24'h010000;
      cfg_act_min = 8'(-128);
      cfg_act_max = 8'(127);
   endtask

endmodule
